FILE: sv/cursor_doubly_linked_list_assert.svh
// Assertion macros shared by the cursor list design.
`ifndef CURSOR_DOUBLY_LINKED_LIST_ASSERT_SVH
`define CURSOR_DOUBLY_LINKED_LIST_ASSERT_SVH

// A condition that holds at every clock edge outside reset.
`define CDLL_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// A consequence that holds in the same cycle as its trigger.
`define CDLL_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// A consequence that holds in the cycle after its trigger.
`define CDLL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/cdll_pkg.sv
// Shared operation codes, status codes and types of the cursor list.
package cdll_pkg;

    localparam int OP_W   = 4;
    localparam int STAT_W = 3;

    typedef logic [OP_W-1:0]   op_t;
    typedef logic [STAT_W-1:0] status_t;

    localparam op_t OP_INS_BEFORE = 4'd0;
    localparam op_t OP_INS_AFTER  = 4'd1;
    localparam op_t OP_REM_BEFORE = 4'd2;
    localparam op_t OP_REM_AFTER  = 4'd3;
    localparam op_t OP_LEFT       = 4'd4;
    localparam op_t OP_RIGHT      = 4'd5;
    localparam op_t OP_FIRST      = 4'd6;
    localparam op_t OP_LAST       = 4'd7;
    localparam op_t OP_CLEAR      = 4'd8;

    localparam status_t STAT_OK       = 3'd0;
    localparam status_t STAT_EMPTY    = 3'd1;
    localparam status_t STAT_NO_MEM   = 3'd2;
    localparam status_t STAT_AT_END   = 3'd3;
    localparam status_t STAT_AT_BEGIN = 3'd4;

    // Write enables of the broadcast write bus: a whole node, one pred link, one succ link.
    typedef struct packed {
        logic node;
        logic pred;
        logic succ;
    } wr_en_t;

endpackage

FILE: sv/cdll_if.sv
// Request and response channel interfaces of the cursor list.
interface cdll_req_if
    import cdll_pkg::*;
#(
    parameter int DATA_WIDTH = 32
);
    logic                         valid;
    logic                         ready;
    op_t                          operation;
    logic signed [DATA_WIDTH-1:0] value;

    modport source (output valid, output operation, output value, input ready);
    modport sink   (input valid, input operation, input value, output ready);
endinterface

interface cdll_rsp_if
    import cdll_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int CNT_W      = 5
);
    logic                         valid;
    logic                         ready;
    status_t                      status;
    logic signed [DATA_WIDTH-1:0] removed_value;
    logic [CNT_W-1:0]             element_count;

    modport source (output valid, output status, output removed_value, output element_count,
                    input ready);
    modport sink   (input valid, input status, input removed_value, input element_count,
                    output ready);
endinterface

FILE: sv/cdll_cell.sv
// One node cell: holds a node's data and links and forwards the read pipe.
module cdll_cell
    import cdll_pkg::*;
#(
    parameter int IDX_W      = 4,
    parameter int DATA_WIDTH = 32,
    parameter int CELL_ID    = 0
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  wr_en_t                wr_en,
    input  logic [IDX_W-1:0]      wr_node_idx,
    input  logic [DATA_WIDTH-1:0] wr_data,
    input  logic [IDX_W-1:0]      wr_pred,
    input  logic [IDX_W-1:0]      wr_succ,
    input  logic [IDX_W-1:0]      wr_pred_idx,
    input  logic [IDX_W-1:0]      wr_pred_val,
    input  logic [IDX_W-1:0]      wr_succ_idx,
    input  logic [IDX_W-1:0]      wr_succ_val,
    input  logic                  in_valid,
    input  logic [IDX_W-1:0]      in_idx,
    input  logic [DATA_WIDTH-1:0] in_data,
    input  logic [IDX_W-1:0]      in_pred,
    input  logic [IDX_W-1:0]      in_succ,
    output logic                  out_valid,
    output logic [IDX_W-1:0]      out_idx,
    output logic [DATA_WIDTH-1:0] out_data,
    output logic [IDX_W-1:0]      out_pred,
    output logic [IDX_W-1:0]      out_succ
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_ID);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [IDX_W-1:0]      pred_reg;
    logic [IDX_W-1:0]      succ_reg;
    logic                  valid_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic [DATA_WIDTH-1:0] rd_data_reg;
    logic [IDX_W-1:0]      rd_pred_reg;
    logic [IDX_W-1:0]      rd_succ_reg;

    // Node storage. A whole-node write wins over a single link write.
    always_ff @(posedge clk)
    begin
        if (wr_en.node && wr_node_idx == MY_IDX)
        begin
            data_reg <= wr_data;
            pred_reg <= wr_pred;
            succ_reg <= wr_succ;
        end
        else
        begin
            if (wr_en.pred && wr_pred_idx == MY_IDX)
            begin
                pred_reg <= wr_pred_val;
            end
            if (wr_en.succ && wr_succ_idx == MY_IDX)
            begin
                succ_reg <= wr_succ_val;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    // The read request moves one cell per cycle; the addressed cell puts its node on it.
    always_ff @(posedge clk)
    begin
        idx_reg <= in_idx;
        if (in_valid && in_idx == MY_IDX)
        begin
            rd_data_reg <= data_reg;
            rd_pred_reg <= pred_reg;
            rd_succ_reg <= succ_reg;
        end
        else
        begin
            rd_data_reg <= in_data;
            rd_pred_reg <= in_pred;
            rd_succ_reg <= in_succ;
        end
    end

    assign out_valid = valid_reg;
    assign out_idx   = idx_reg;
    assign out_data  = rd_data_reg;
    assign out_pred  = rd_pred_reg;
    assign out_succ  = rd_succ_reg;

endmodule

FILE: sv/cdll_row.sv
// Row of node cells: a broadcast write bus and a read pipe running through every cell.
module cdll_row
    import cdll_pkg::*;
#(
    parameter int NODE_COUNT = 16,
    parameter int DATA_WIDTH = 32,
    parameter int IDX_W      = 4
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  wr_en_t                wr_en,
    input  logic [IDX_W-1:0]      wr_node_idx,
    input  logic [DATA_WIDTH-1:0] wr_data,
    input  logic [IDX_W-1:0]      wr_pred,
    input  logic [IDX_W-1:0]      wr_succ,
    input  logic [IDX_W-1:0]      wr_pred_idx,
    input  logic [IDX_W-1:0]      wr_pred_val,
    input  logic [IDX_W-1:0]      wr_succ_idx,
    input  logic [IDX_W-1:0]      wr_succ_val,
    input  logic                  rd_valid,
    input  logic [IDX_W-1:0]      rd_idx,
    output logic                  rd_done,
    output logic [DATA_WIDTH-1:0] rd_data,
    output logic [IDX_W-1:0]      rd_pred,
    output logic [IDX_W-1:0]      rd_succ
);

    logic                  ch_valid [NODE_COUNT+1];
    logic [IDX_W-1:0]      ch_idx   [NODE_COUNT+1];
    logic [DATA_WIDTH-1:0] ch_data  [NODE_COUNT+1];
    logic [IDX_W-1:0]      ch_pred  [NODE_COUNT+1];
    logic [IDX_W-1:0]      ch_succ  [NODE_COUNT+1];

    // A read that matches no cell comes out as zero.
    assign ch_valid[0] = rd_valid;
    assign ch_idx[0]   = rd_idx;
    assign ch_data[0]  = '0;
    assign ch_pred[0]  = '0;
    assign ch_succ[0]  = '0;

    for (genvar i = 0; i < NODE_COUNT; i++)
    begin : g_cell
        cdll_cell #(
            .IDX_W      (IDX_W),
            .DATA_WIDTH (DATA_WIDTH),
            .CELL_ID    (i)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .wr_en       (wr_en),
            .wr_node_idx (wr_node_idx),
            .wr_data     (wr_data),
            .wr_pred     (wr_pred),
            .wr_succ     (wr_succ),
            .wr_pred_idx (wr_pred_idx),
            .wr_pred_val (wr_pred_val),
            .wr_succ_idx (wr_succ_idx),
            .wr_succ_val (wr_succ_val),
            .in_valid    (ch_valid[i]),
            .in_idx      (ch_idx[i]),
            .in_data     (ch_data[i]),
            .in_pred     (ch_pred[i]),
            .in_succ     (ch_succ[i]),
            .out_valid   (ch_valid[i+1]),
            .out_idx     (ch_idx[i+1]),
            .out_data    (ch_data[i+1]),
            .out_pred    (ch_pred[i+1]),
            .out_succ    (ch_succ[i+1])
        );
    end

    assign rd_done = ch_valid[NODE_COUNT];
    assign rd_data = ch_data[NODE_COUNT];
    assign rd_pred = ch_pred[NODE_COUNT];
    assign rd_succ = ch_succ[NODE_COUNT];

endmodule

FILE: sv/cursor_doubly_linked_list.sv
// Top level of the cursor list: operation sequencer, list registers and result register.
//
// The block keeps a doubly linked list of data words in a pool of NODE_COUNT nodes and
// a cursor into it. Each transfer on the req channel carries one operation (insert
// before or after the cursor, remove the neighbor before or after it, move left or
// right, jump to first or last, clear) and yields exactly one transfer on the rsp
// channel with a status, the removed word (zero unless something was removed) and the
// element count after the operation.
// The nodes live in a row of NODE_COUNT cells. A node read walks the row one cell per
// cycle. No node is read for first, last, clear, an insert into an empty list, whose
// pool then holds only never-used nodes, and the cases that only report a status; one
// node is read for moves, removes past an edge and inserts into a non-empty list that
// take a never-used node; two nodes are read, one after the other, for interior
// removes and inserts that take a recycled node.
// One operation is in work at a time; req is ready again from the edge that writes the
// result.
// The result register holds a result until rsp is ready; a new request may be taken
// meanwhile, and its result waits in the final step until the register is free.
// Reset empties the list and the free pool; node contents are not cleared.
`include "cursor_doubly_linked_list_assert.svh"

module cursor_doubly_linked_list
    import cdll_pkg::*;
#(
    parameter int NODE_COUNT = 16,
    parameter int DATA_WIDTH = 32
)
(
    input  logic      clk,
    input  logic      rst_n,
    cdll_req_if.sink  req,
    cdll_rsp_if.source rsp
);

    localparam int IDX_W = $clog2(NODE_COUNT);
    localparam int CNT_W = $clog2(NODE_COUNT + 1);
    localparam logic [CNT_W-1:0] NODE_MAX = CNT_W'(NODE_COUNT);

    // Sequencer states.
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_WAIT1 = 2'd1;
    localparam logic [1:0] S_WAIT2 = 2'd2;
    localparam logic [1:0] S_EXEC  = 2'd3;

    // Where a node read lands: the cursor's node or the auxiliary node.
    localparam logic TAG_CUR = 1'b0;
    localparam logic TAG_AUX = 1'b1;

    logic [1:0]            state_reg, state_next;
    logic                  tag_reg, tag_next;
    op_t                   op_reg;
    logic [DATA_WIDTH-1:0] val_reg;

    logic [DATA_WIDTH-1:0] cur_data_reg, aux_data_reg;
    logic [IDX_W-1:0]      cur_pred_reg, cur_succ_reg, aux_pred_reg, aux_succ_reg;

    logic [IDX_W-1:0]      head_reg, head_next;
    logic [IDX_W-1:0]      tail_reg, tail_next;
    logic [IDX_W-1:0]      cursor_reg, cursor_next;
    logic [IDX_W-1:0]      free_reg, free_next;
    logic [CNT_W-1:0]      used_reg, used_next;
    logic [CNT_W-1:0]      fresh_reg, fresh_next;

    logic                  out_valid_reg, out_valid_next;
    status_t               status_reg, status_next;
    logic [DATA_WIDTH-1:0] removed_reg, removed_next;
    logic [CNT_W-1:0]      count_reg;

    logic                  accept, commit;
    logic                  list_empty, pool_free, can_fresh, take_ok;
    logic [IDX_W-1:0]      take_idx;

    logic                  rd_valid, rd_done;
    logic [IDX_W-1:0]      rd_idx, rd_pred, rd_succ;
    logic [DATA_WIDTH-1:0] rd_data;

    wr_en_t                wr_en_c, wr_en;
    logic [IDX_W-1:0]      wr_node_idx, wr_pred, wr_succ;
    logic [IDX_W-1:0]      wr_pred_idx, wr_pred_val, wr_succ_idx, wr_succ_val;
    logic [DATA_WIDTH-1:0] wr_data;

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    // The final step writes only once the result register is free or being emptied.
    assign commit    = (state_reg == S_EXEC) && (!out_valid_reg || rsp.ready);

    assign list_empty = (used_reg == '0);
    assign pool_free  = (used_reg < fresh_reg);
    assign can_fresh  = (fresh_reg < NODE_MAX);
    assign take_ok    = pool_free || can_fresh;
    // Recycled nodes come first; otherwise the next never-used node.
    assign take_idx   = pool_free ? free_reg : fresh_reg[IDX_W-1:0];

    // Sequencer: decide which node reads an operation needs and launch them.
    always_comb
    begin
        state_next = state_reg;
        tag_next   = tag_reg;
        rd_valid   = 1'b0;
        rd_idx     = cursor_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (req.operation)
                        OP_INS_BEFORE, OP_INS_AFTER:
                        begin
                            if (list_empty)
                            begin
                                if (pool_free)
                                begin
                                    rd_valid = 1'b1;
                                    rd_idx   = free_reg;
                                    tag_next = TAG_AUX;
                                end
                            end
                            else if (take_ok)
                            begin
                                rd_valid = 1'b1;
                                tag_next = TAG_CUR;
                            end
                        end
                        OP_REM_BEFORE, OP_REM_AFTER:
                        begin
                            rd_valid = !list_empty;
                            tag_next = TAG_CUR;
                        end
                        OP_LEFT:
                        begin
                            rd_valid = !list_empty && (cursor_reg != head_reg);
                            tag_next = TAG_CUR;
                        end
                        OP_RIGHT:
                        begin
                            rd_valid = !list_empty && (cursor_reg != tail_reg);
                            tag_next = TAG_CUR;
                        end
                        default:
                        begin
                            rd_valid = 1'b0;
                        end
                    endcase
                    state_next = rd_valid ? S_WAIT1 : S_EXEC;
                end
            end
            S_WAIT1:
            begin
                if (rd_done)
                begin
                    state_next = S_EXEC;
                    case (op_reg)
                        OP_INS_BEFORE, OP_INS_AFTER:
                        begin
                            // The cursor node is in; a recycled node needs its free link.
                            if (tag_reg == TAG_CUR && pool_free)
                            begin
                                rd_valid = 1'b1;
                                rd_idx   = free_reg;
                            end
                        end
                        OP_REM_BEFORE:
                        begin
                            if (cursor_reg != head_reg)
                            begin
                                rd_valid = 1'b1;
                                rd_idx   = rd_pred;
                            end
                        end
                        OP_REM_AFTER:
                        begin
                            if (cursor_reg != tail_reg)
                            begin
                                rd_valid = 1'b1;
                                rd_idx   = rd_succ;
                            end
                        end
                        default:
                        begin
                            rd_valid = 1'b0;
                        end
                    endcase
                    if (rd_valid)
                    begin
                        tag_next   = TAG_AUX;
                        state_next = S_WAIT2;
                    end
                end
            end
            S_WAIT2:
            begin
                if (rd_done)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (commit)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Final step: list register updates, node writes and the result.
    always_comb
    begin
        head_next    = head_reg;
        tail_next    = tail_reg;
        cursor_next  = cursor_reg;
        free_next    = free_reg;
        used_next    = used_reg;
        fresh_next   = fresh_reg;
        status_next  = STAT_OK;
        removed_next = '0;
        wr_en_c      = '0;
        wr_node_idx  = take_idx;
        wr_data      = val_reg;
        wr_pred      = take_idx;
        wr_succ      = take_idx;
        wr_pred_idx  = cursor_reg;
        wr_pred_val  = take_idx;
        wr_succ_idx  = cursor_reg;
        wr_succ_val  = take_idx;
        case (op_reg)
            OP_INS_BEFORE, OP_INS_AFTER:
            begin
                if (list_empty || take_ok)
                begin
                    if (take_ok)
                    begin
                        if (pool_free)
                        begin
                            free_next = aux_succ_reg;
                        end
                        else
                        begin
                            fresh_next = fresh_reg + CNT_W'(1);
                        end
                        used_next    = used_reg + CNT_W'(1);
                        wr_en_c.node = 1'b1;
                    end
                    if (list_empty)
                    begin
                        // The first node links to itself and carries head, tail and cursor.
                        head_next   = take_idx;
                        tail_next   = take_idx;
                        cursor_next = take_idx;
                    end
                    else if (op_reg == OP_INS_BEFORE)
                    begin
                        wr_succ      = cursor_reg;
                        wr_pred      = cur_pred_reg;
                        if (cursor_reg != head_reg)
                        begin
                            wr_en_c.succ = 1'b1;
                            wr_succ_idx  = cur_pred_reg;
                        end
                        else
                        begin
                            head_next = take_idx;
                        end
                        wr_en_c.pred = 1'b1;
                        wr_pred_idx  = cursor_reg;
                    end
                    else
                    begin
                        wr_pred      = cursor_reg;
                        wr_succ      = cur_succ_reg;
                        if (cursor_reg != tail_reg)
                        begin
                            wr_en_c.pred = 1'b1;
                            wr_pred_idx  = cur_succ_reg;
                        end
                        else
                        begin
                            tail_next = take_idx;
                        end
                        wr_en_c.succ = 1'b1;
                        wr_succ_idx  = cursor_reg;
                    end
                end
                else
                begin
                    status_next = STAT_NO_MEM;
                end
            end
            OP_REM_BEFORE, OP_REM_AFTER:
            begin
                if (list_empty)
                begin
                    status_next = STAT_EMPTY;
                end
                else if ((op_reg == OP_REM_BEFORE && cursor_reg == head_reg)
                         || (op_reg == OP_REM_AFTER && cursor_reg == tail_reg))
                begin
                    // Removing past an edge hands back the cursor's word and drops the list.
                    removed_next = cur_data_reg;
                    status_next  = (op_reg == OP_REM_BEFORE) ? STAT_AT_BEGIN : STAT_AT_END;
                    used_next    = '0;
                    fresh_next   = '0;
                    free_next    = '0;
                end
                else
                begin
                    removed_next = aux_data_reg;
                    // The removed node goes to the front of the free list.
                    wr_en_c.node = 1'b1;
                    wr_data      = aux_data_reg;
                    wr_pred      = aux_pred_reg;
                    wr_succ      = free_reg;
                    used_next    = used_reg - CNT_W'(1);
                    if (op_reg == OP_REM_BEFORE)
                    begin
                        wr_node_idx = cur_pred_reg;
                        free_next   = cur_pred_reg;
                        if (cur_pred_reg != head_reg)
                        begin
                            wr_en_c.succ = 1'b1;
                            wr_succ_idx  = aux_pred_reg;
                            wr_succ_val  = cursor_reg;
                        end
                        else
                        begin
                            head_next = cursor_reg;
                        end
                        wr_en_c.pred = 1'b1;
                        wr_pred_idx  = cursor_reg;
                        wr_pred_val  = aux_pred_reg;
                    end
                    else
                    begin
                        wr_node_idx = cur_succ_reg;
                        free_next   = cur_succ_reg;
                        if (cur_succ_reg != tail_reg)
                        begin
                            wr_en_c.pred = 1'b1;
                            wr_pred_idx  = aux_succ_reg;
                            wr_pred_val  = cursor_reg;
                        end
                        else
                        begin
                            tail_next = cursor_reg;
                        end
                        wr_en_c.succ = 1'b1;
                        wr_succ_idx  = cursor_reg;
                        wr_succ_val  = aux_succ_reg;
                    end
                end
            end
            OP_LEFT:
            begin
                if (!list_empty && cursor_reg != head_reg)
                begin
                    cursor_next = cur_pred_reg;
                end
                else
                begin
                    status_next = STAT_AT_BEGIN;
                end
            end
            OP_RIGHT:
            begin
                if (!list_empty && cursor_reg != tail_reg)
                begin
                    cursor_next = cur_succ_reg;
                end
                else
                begin
                    status_next = STAT_AT_END;
                end
            end
            OP_FIRST:
            begin
                cursor_next = head_reg;
            end
            OP_LAST:
            begin
                cursor_next = tail_reg;
            end
            OP_CLEAR:
            begin
                used_next  = '0;
                fresh_next = '0;
                free_next  = '0;
            end
            default:
            begin
                status_next = STAT_OK;
            end
        endcase
    end

    assign wr_en = commit ? wr_en_c : '0;

    always_comb
    begin
        if (commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    cdll_row #(
        .NODE_COUNT (NODE_COUNT),
        .DATA_WIDTH (DATA_WIDTH),
        .IDX_W      (IDX_W)
    ) u_row (
        .clk         (clk),
        .rst_n       (rst_n),
        .wr_en       (wr_en),
        .wr_node_idx (wr_node_idx),
        .wr_data     (wr_data),
        .wr_pred     (wr_pred),
        .wr_succ     (wr_succ),
        .wr_pred_idx (wr_pred_idx),
        .wr_pred_val (wr_pred_val),
        .wr_succ_idx (wr_succ_idx),
        .wr_succ_val (wr_succ_val),
        .rd_valid    (rd_valid),
        .rd_idx      (rd_idx),
        .rd_done     (rd_done),
        .rd_data     (rd_data),
        .rd_pred     (rd_pred),
        .rd_succ     (rd_succ)
    );

    // Control and list registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            tag_reg       <= TAG_CUR;
            head_reg      <= '0;
            tail_reg      <= '0;
            cursor_reg    <= '0;
            free_reg      <= '0;
            used_reg      <= '0;
            fresh_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tag_reg       <= tag_next;
            out_valid_reg <= out_valid_next;
            if (commit)
            begin
                head_reg   <= head_next;
                tail_reg   <= tail_next;
                cursor_reg <= cursor_next;
                free_reg   <= free_next;
                used_reg   <= used_next;
                fresh_reg  <= fresh_next;
            end
        end
    end

    // Payload registers: the request, the nodes read back and the result.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= req.operation;
            val_reg <= req.value;
        end
        if (rd_done)
        begin
            if (tag_reg == TAG_CUR)
            begin
                cur_data_reg <= rd_data;
                cur_pred_reg <= rd_pred;
                cur_succ_reg <= rd_succ;
            end
            else
            begin
                aux_data_reg <= rd_data;
                aux_pred_reg <= rd_pred;
                aux_succ_reg <= rd_succ;
            end
        end
        if (commit)
        begin
            status_reg  <= status_next;
            removed_reg <= removed_next;
            count_reg   <= used_next;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = status_reg;
    assign rsp.removed_value = removed_reg;
    assign rsp.element_count = count_reg;

    // The pool never hands out more nodes than it has, nor counts more in use than handed out.
    `CDLL_ASSERT_ALWAYS(a_used_within_fresh, clk, rst_n,
        used_reg <= fresh_reg && fresh_reg <= NODE_MAX,
        "element count exceeds nodes handed out")
    // Read data only returns while the sequencer waits for it.
    `CDLL_ASSERT_IMPLIES(a_read_while_waiting, clk, rst_n, rd_done,
        state_reg == S_WAIT1 || state_reg == S_WAIT2,
        "node read returned outside a wait state")
    // A new result appears only as the final step of an operation.
    `CDLL_ASSERT_IMPLIES(a_result_from_exec, clk, rst_n, $rose(out_valid_reg),
        $past(state_reg) == S_EXEC, "result raised outside the final step")
    // An accepted request always starts work.
    `CDLL_ASSERT_NEXT(a_accept_starts_work, clk, rst_n, req.valid && req.ready,
        state_reg != S_IDLE, "accepted request left the sequencer idle")

endmodule
